FILE: design/agi_pkg.sv
// Shared types, breakpoint tables and fixed-point slope constants for the grain size lookup.
package agi_pkg;

  localparam int AGE_W       = 32;
  localparam int SIZE_W      = 24;
  localparam int OFF_W       = 24;
  localparam int TABLE_POINTS = 22;
  localparam int NUM_SEGS    = TABLE_POINTS - 1;
  localparam int NUM_INNER   = TABLE_POINTS - 2;
  localparam int SEG_W       = 5;
  localparam int SLOPE_FRAC  = 24;
  localparam int SLOPE_W     = 33;
  localparam int SLOPE_LO_W  = 17;
  localparam int SLOPE_HI_W  = SLOPE_W - SLOPE_LO_W;
  localparam int PROD_W      = OFF_W + SLOPE_W;
  localparam int INC_W       = PROD_W - SLOPE_FRAC;

  localparam logic [AGE_W-1:0] AGE_PTS [TABLE_POINTS] = '{
    32'd0, 32'd50000, 32'd100000, 32'd125000, 32'd150000,
    32'd158000, 32'd165000, 32'd170000, 32'd180000, 32'd188000,
    32'd200000, 32'd225000, 32'd245000, 32'd260000, 32'd300000,
    32'd320000, 32'd350000, 32'd400000, 32'd500000, 32'd600000,
    32'd800000, 32'd10000000
  };

  localparam logic [SIZE_W-1:0] SIZE_PTS [TABLE_POINTS] = '{
    24'd1800000, 24'd2200000, 24'd3000000, 24'd4000000, 24'd4300000,
    24'd3000000, 24'd3000000, 24'd4600000, 24'd3400000, 24'd3300000,
    24'd5900000, 24'd6200000, 24'd5400000, 24'd6800000, 24'd3500000,
    24'd6000000, 24'd8000000, 24'd8300000, 24'd3600000, 24'd3800000,
    24'd9500000, 24'd10000000
  };

  // Slope magnitude in nm per year with SLOPE_FRAC fractional bits, rounded to nearest.
  localparam logic [SLOPE_W-1:0] SLOPE_MAG [NUM_SEGS] = '{
    SLOPE_W'(((64'd400000  << SLOPE_FRAC) + 64'd50000 / 2)   / 64'd50000),
    SLOPE_W'(((64'd800000  << SLOPE_FRAC) + 64'd50000 / 2)   / 64'd50000),
    SLOPE_W'(((64'd1000000 << SLOPE_FRAC) + 64'd25000 / 2)   / 64'd25000),
    SLOPE_W'(((64'd300000  << SLOPE_FRAC) + 64'd25000 / 2)   / 64'd25000),
    SLOPE_W'(((64'd1300000 << SLOPE_FRAC) + 64'd8000 / 2)    / 64'd8000),
    SLOPE_W'(((64'd0       << SLOPE_FRAC) + 64'd7000 / 2)    / 64'd7000),
    SLOPE_W'(((64'd1600000 << SLOPE_FRAC) + 64'd5000 / 2)    / 64'd5000),
    SLOPE_W'(((64'd1200000 << SLOPE_FRAC) + 64'd10000 / 2)   / 64'd10000),
    SLOPE_W'(((64'd100000  << SLOPE_FRAC) + 64'd8000 / 2)    / 64'd8000),
    SLOPE_W'(((64'd2600000 << SLOPE_FRAC) + 64'd12000 / 2)   / 64'd12000),
    SLOPE_W'(((64'd300000  << SLOPE_FRAC) + 64'd25000 / 2)   / 64'd25000),
    SLOPE_W'(((64'd800000  << SLOPE_FRAC) + 64'd20000 / 2)   / 64'd20000),
    SLOPE_W'(((64'd1400000 << SLOPE_FRAC) + 64'd15000 / 2)   / 64'd15000),
    SLOPE_W'(((64'd3300000 << SLOPE_FRAC) + 64'd40000 / 2)   / 64'd40000),
    SLOPE_W'(((64'd2500000 << SLOPE_FRAC) + 64'd20000 / 2)   / 64'd20000),
    SLOPE_W'(((64'd2000000 << SLOPE_FRAC) + 64'd30000 / 2)   / 64'd30000),
    SLOPE_W'(((64'd300000  << SLOPE_FRAC) + 64'd50000 / 2)   / 64'd50000),
    SLOPE_W'(((64'd4700000 << SLOPE_FRAC) + 64'd100000 / 2)  / 64'd100000),
    SLOPE_W'(((64'd200000  << SLOPE_FRAC) + 64'd100000 / 2)  / 64'd100000),
    SLOPE_W'(((64'd5700000 << SLOPE_FRAC) + 64'd200000 / 2)  / 64'd200000),
    SLOPE_W'(((64'd500000  << SLOPE_FRAC) + 64'd9200000 / 2) / 64'd9200000)
  };

  // Set where the size falls across the segment.
  localparam logic SLOPE_NEG [NUM_SEGS] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
    1'b0
  };

  typedef struct packed {
    logic             hi;
    logic [SEG_W-1:0] seg;
    logic [OFF_W-1:0] age;
  } seg_item_t;

  typedef struct packed {
    logic              hi;
    logic              neg;
    logic [SIZE_W-1:0] base;
    logic [INC_W-1:0]  inc;
  } inc_item_t;

endpackage

FILE: design/agi_seg_find.sv
// Two-stage segment search: breakpoint compares, then priority encoding of the segment.
module agi_seg_find (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               age,
  output logic                      out_valid,
  input  logic                      out_ready,
  output agi_pkg::seg_item_t        out_item
);
  import agi_pkg::*;

  logic                 v1;
  logic [NUM_INNER-1:0] ge1;
  logic                 hi1;
  logic [OFF_W-1:0]     age1;
  logic                 v2;
  seg_item_t            item2;
  logic                 rdy1;
  logic                 rdy2;
  logic [NUM_INNER-1:0] ge_next;
  logic [SEG_W-1:0]     seg_next;

  assign rdy2      = !v2 || out_ready;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2;
  assign out_item  = item2;

  always_comb begin
    for (int i = 0; i < NUM_INNER; i++) begin
      ge_next[i] = (age >= AGE_PTS[i + 1]);
    end
  end

  always_comb begin
    seg_next = '0;
    for (int i = 0; i < NUM_INNER; i++) begin
      if (ge1[i]) begin
        seg_next = SEG_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      ge1  <= ge_next;
      hi1  <= (age >= AGE_PTS[TABLE_POINTS - 1]);
      age1 <= age[OFF_W-1:0];
    end
    if (rdy2 && v1) begin
      item2.hi  <= hi1;
      item2.seg <= seg_next;
      item2.age <= age1;
    end
  end

endmodule

FILE: design/agi_slope_mul.sv
// Three-stage offset, split slope multiply and rounding of the increment.
module agi_slope_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  agi_pkg::seg_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output agi_pkg::inc_item_t   out_item
);
  import agi_pkg::*;

  logic                         v3;
  logic [OFF_W-1:0]             off3;
  logic [SLOPE_W-1:0]           slope3;
  logic                         neg3;
  logic                         hi3;
  logic [SIZE_W-1:0]            base3;
  logic                         v4;
  logic [OFF_W+SLOPE_LO_W-1:0]  pp_lo4;
  logic [OFF_W+SLOPE_HI_W-1:0]  pp_hi4;
  logic                         neg4;
  logic                         hi4;
  logic [SIZE_W-1:0]            base4;
  logic                         v5;
  inc_item_t                    item5;
  logic                         rdy3;
  logic                         rdy4;
  logic                         rdy5;
  logic [PROD_W-1:0]            prod_next;

  assign rdy5      = !v5 || out_ready;
  assign rdy4      = !v4 || rdy5;
  assign rdy3      = !v3 || rdy4;
  assign in_ready  = rdy3;
  assign out_valid = v5;
  assign out_item  = item5;

  assign prod_next = {pp_hi4, {SLOPE_LO_W{1'b0}}}
                   + PROD_W'(pp_lo4)
                   + (PROD_W'(1) << (SLOPE_FRAC - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy3) begin
        v3 <= in_valid;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        v5 <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      off3   <= in_item.age - AGE_PTS[in_item.seg][OFF_W-1:0];
      slope3 <= SLOPE_MAG[in_item.seg];
      neg3   <= SLOPE_NEG[in_item.seg];
      base3  <= SIZE_PTS[in_item.seg];
      hi3    <= in_item.hi;
    end
    if (rdy4 && v3) begin
      pp_lo4 <= (OFF_W + SLOPE_LO_W)'(off3) * (OFF_W + SLOPE_LO_W)'(slope3[SLOPE_LO_W-1:0]);
      pp_hi4 <= (OFF_W + SLOPE_HI_W)'(off3)
              * (OFF_W + SLOPE_HI_W)'(slope3[SLOPE_W-1:SLOPE_LO_W]);
      neg4   <= neg3;
      base4  <= base3;
      hi4    <= hi3;
    end
    if (rdy5 && v4) begin
      item5.inc  <= prod_next[PROD_W-1:SLOPE_FRAC];
      item5.neg  <= neg4;
      item5.base <= base4;
      item5.hi   <= hi4;
    end
  end

endmodule

FILE: design/agi_apply.sv
// Output register: signed increment applied to the left size, floored at zero; ages past the table give the last size.
module agi_apply (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  agi_pkg::inc_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [23:0]          size
);
  import agi_pkg::*;

  logic              v6;
  logic              rdy6;
  logic [SIZE_W-1:0] size_next;

  assign rdy6      = !v6 || out_ready;
  assign in_ready  = rdy6;
  assign out_valid = v6;

  always_comb begin
    if (in_item.hi) begin
      size_next = SIZE_PTS[TABLE_POINTS - 1];
    end else if (in_item.neg) begin
      if (in_item.inc >= INC_W'(in_item.base)) begin
        size_next = '0;
      end else begin
        size_next = in_item.base - in_item.inc[SIZE_W-1:0];
      end
    end else begin
      size_next = in_item.base + in_item.inc[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (rdy6) begin
      v6 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6 && in_valid) begin
      size <= size_next;
    end
  end

endmodule

FILE: design/age_to_grain_size_interp.sv
// Each accepted input passes the segment search, slope multiply and apply stages in order before it shows on m_tvalid.
// Throughput: one transaction per cycle unless the master side stalls; six-stage pipeline with one multiply stage.
// A stall on the master side holds every full stage; empty stages still fill, so bubbles are squeezed out.
// Reset clears the valid bit of every stage; the tables are constants and need no reset.
module age_to_grain_size_interp (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] age_years
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [23:0] grain_size_nm
);
  import agi_pkg::*;

  logic      seg_valid;
  logic      seg_ready;
  seg_item_t seg_item;
  logic      inc_valid;
  logic      inc_ready;
  inc_item_t inc_item;

  agi_seg_find u_seg_find (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .age       (s_tdata),
    .out_valid (seg_valid),
    .out_ready (seg_ready),
    .out_item  (seg_item)
  );

  agi_slope_mul u_slope_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seg_valid),
    .in_ready  (seg_ready),
    .in_item   (seg_item),
    .out_valid (inc_valid),
    .out_ready (inc_ready),
    .out_item  (inc_item)
  );

  agi_apply u_apply (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (inc_valid),
    .in_ready  (inc_ready),
    .in_item   (inc_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .size      (m_tdata)
  );

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata >= SIZE_PTS[0]) && (m_tdata <= SIZE_PTS[TABLE_POINTS - 1]))
    else $error("grain size result outside the table range");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("pipeline not ready although the output side is taking results");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid straight after reset");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the age to grain size interpolating lookup.
module testbench;

  localparam int AGE_BITS  = agi_pkg::AGE_W;
  localparam int SIZE_BITS = agi_pkg::SIZE_W;
  localparam int RANDOM_AGES = 1650;
  localparam int DRAIN_CYCLES = 20;

  class grain_scoreboard;
    bit [31:0] bp_age [22] = '{
      32'd0, 32'd50000, 32'd100000, 32'd125000, 32'd150000,
      32'd158000, 32'd165000, 32'd170000, 32'd180000, 32'd188000,
      32'd200000, 32'd225000, 32'd245000, 32'd260000, 32'd300000,
      32'd320000, 32'd350000, 32'd400000, 32'd500000, 32'd600000,
      32'd800000, 32'd10000000
    };
    bit [23:0] bp_size [22] = '{
      24'd1800000, 24'd2200000, 24'd3000000, 24'd4000000, 24'd4300000,
      24'd3000000, 24'd3000000, 24'd4600000, 24'd3400000, 24'd3300000,
      24'd5900000, 24'd6200000, 24'd5400000, 24'd6800000, 24'd3500000,
      24'd6000000, 24'd8000000, 24'd8300000, 24'd3600000, 24'd3800000,
      24'd9500000, 24'd10000000
    };
    logic [SIZE_BITS-1:0] pending_sizes [$];
    int mismatches = 0;

    function logic [SIZE_BITS-1:0] predict_grain_size(logic [AGE_BITS-1:0] age);
      int seg;
      bit falling;
      bit [63:0] span, rise, slope, prod, incr, base, sum;
      if (age <= bp_age[0]) return bp_size[0];
      if (age >= bp_age[21]) return bp_size[21];
      seg = 0;
      for (int i = 1; i < 21; i++)
        if (bp_age[i] <= age) seg = i;
      span = 64'(bp_age[seg+1]) - 64'(bp_age[seg]);
      falling = bp_size[seg+1] < bp_size[seg];
      rise = falling ? 64'(bp_size[seg]) - 64'(bp_size[seg+1])
                     : 64'(bp_size[seg+1]) - 64'(bp_size[seg]);
      // Slope magnitude in Q.24 nm per year, rounded half up.
      slope = ((rise << 24) + span / 2) / span;
      prod = 64'(age - bp_age[seg]) * slope;
      incr = (prod + (64'd1 << 23)) >> 24;
      base = 64'(bp_size[seg]);
      if (falling)
        sum = (incr >= base) ? 64'd0 : base - incr;
      else
        sum = base + incr;
      return sum[SIZE_BITS-1:0];
    endfunction

    function void note_age(logic [AGE_BITS-1:0] age);
      pending_sizes.push_back(predict_grain_size(age));
    endfunction

    task report(string msg);
      $display("error at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_size(logic [SIZE_BITS-1:0] got);
      logic [SIZE_BITS-1:0] want;
      if (pending_sizes.size() == 0) begin
        report($sformatf("grain size %0d arrived with nothing outstanding", got));
      end else begin
        want = pending_sizes.pop_front();
        if (got !== want)
          report($sformatf("grain_size_nm %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [AGE_BITS-1:0]  s_tdata;   // [31:0] age_years
  logic                 m_tvalid;
  logic                 m_tready;
  logic [SIZE_BITS-1:0] m_tdata;   // [23:0] grain_size_nm

  grain_scoreboard sb = new();
  bit calm = 1'b0;

  age_to_grain_size_interp DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_age(input logic [AGE_BITS-1:0] age, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= age;
    do @(posedge clk); while (!s_tready);
    sb.note_age(age);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending_sizes.size() != 0);
  endtask

  function automatic logic [AGE_BITS-1:0] pick_age();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return $urandom_range(0, 800000);
    if (sel < 70) return $urandom_range(800000, 10000000);
    if (sel < 85) return sb.bp_age[$urandom_range(0, 21)] + $urandom_range(0, 6) - 3;
    return $urandom();
  endfunction

  initial begin
    int stall;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_size(m_tdata);
      @(negedge clk);
    end
  end

  initial begin
    logic [AGE_BITS-1:0] directed [20] = '{
      32'd0, 32'd1, 32'd49999, 32'd50000, 32'd158000, 32'd161234, 32'd169999,
      32'd170000, 32'd170001, 32'd799999, 32'd800000, 32'd800001, 32'd5400000,
      32'd9999999, 32'd10000000, 32'd10000001, 32'h80000000, 32'hFFFFFFFF,
      32'h55555555, 32'hAAAAAAAA
    };
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) send_age(directed[i], draw_wait());
    wait_drained();

    for (int n = 0; n < RANDOM_AGES; n++) begin
      // Every third stretch of 250 transactions runs with both sides at full rate.
      calm = ((n / 250) % 3) == 2;
      if (n == RANDOM_AGES / 2) wait_drained();
      send_age(pick_age(), draw_wait());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
